/* sv/bbps_pkg.sv */
// Package for the battery backup power sequencer.
// Holds transaction structs, state codes, fault bits and register indexes.
// No dependencies.
package bbps_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BATT_ABSENT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATT_UNDER     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BATT_OVER      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BATT_PRECHARGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BATT_NOMINAL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_CUTOFF  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_LOW     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_MIN     = 3'd7;

  // Fixed supply thresholds and the dwell threshold for slow gains
  localparam logic [15:0] SUPPLY_ABSENT_MV = 16'd1000;
  localparam logic [15:0] SUPPLY_MAX_MV    = 16'd5500;
  localparam logic [15:0] DWELL_SLOW       = 16'd50;

  // Power machine codes
  localparam logic [2:0] PS_BOOT     = 3'd0;
  localparam logic [2:0] PS_STANDBY  = 3'd1;
  localparam logic [2:0] PS_EXTERNAL = 3'd2;
  localparam logic [2:0] PS_NORMAL   = 3'd3;
  localparam logic [2:0] PS_DISCH    = 3'd4;
  localparam logic [2:0] PS_FAULT    = 3'd5;

  // Charge machine codes
  localparam logic [1:0] CS_PRE  = 2'd0;
  localparam logic [1:0] CS_CHG  = 2'd1;
  localparam logic [1:0] CS_DONE = 2'd2;

  // Drive modes
  localparam logic [1:0] DRV_OFF       = 2'd0;
  localparam logic [1:0] DRV_BUCK_QTR  = 2'd1;
  localparam logic [1:0] DRV_BUCK_FULL = 2'd2;
  localparam logic [1:0] DRV_BOOST     = 2'd3;

  // Sticky fault bits
  localparam logic [6:0] FLT_SHORT      = 7'h01;
  localparam logic [6:0] FLT_BATT_UV    = 7'h02;
  localparam logic [6:0] FLT_BATT_OV    = 7'h04;
  localparam logic [6:0] FLT_SUPPLY_UV  = 7'h08;
  localparam logic [6:0] FLT_SUPPLY_OV  = 7'h10;
  localparam logic [6:0] FLT_BAD_POWER  = 7'h20;
  localparam logic [6:0] FLT_BAD_CHARGE = 7'h40;

  typedef struct packed {
    logic [15:0]        supply_mv;
    logic [15:0]        battery_mv;
    logic signed [15:0] battery_ma;
    logic               soft_trip;
    logic               hard_trip;
    logic               five_sec_pulse;
    logic [15:0]        dwell_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0] power_state;
    logic [1:0] charge_state;
    logic       gate_enable;
    logic [1:0] drive_mode;
    logic       fast_gains;
    logic [6:0] fault_codes;
  } out_item_t;

endpackage

/* sv/battery_backup_power_sequencer.sv */
// Top level of the battery backup power sequencer: fault checks, power and
// charge state machines, gate/drive/gain selection. Depends on bbps_pkg.
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_ready  bbps_pkg::in_item_t
//  out_     output     out_valid/out_ready  bbps_pkg::out_item_t
//  cfg_     input      cfg_we (no wait)     cfg_index, cfg_wdata
//
// One measurement tick per clock sustained while the result is not stalled.
// A transaction lands in the input register, then one pass of
// compare-and-select logic updates the state and loads the result register.
// Reset (synchronous, rst_n low) restores thresholds, boot/charged state, a
// clear fault word, slow gains and no pending pulse. When the result is
// stalled, the input register still takes one more transaction before
// in_ready drops.
module battery_backup_power_sequencer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bbps_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bbps_pkg::out_item_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [bbps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bbps_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import bbps_pkg::*;

  // Configuration registers
  logic [15:0] batt_absent_r, batt_under_r, batt_over_r, batt_precharge_r;
  logic [15:0] batt_nominal_r, supply_low_r, supply_min_r;
  logic [14:0] charge_cutoff_r;

  // Sequencer state
  logic [2:0] power_mode_r, power_mode_nxt;
  logic [1:0] charge_mode_r, charge_mode_nxt;
  logic [6:0] fault_word_r, fault_word_nxt;
  logic       gain_select_r, gain_select_nxt;
  logic       pulse_pending_r, pulse_pending_nxt;

  // Pipeline registers
  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  logic advance;

  // Advance the input stage when the result register is empty or drained
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batt_absent_r    <= 16'd500;
      batt_under_r     <= 16'd2500;
      batt_over_r      <= 16'd4300;
      batt_precharge_r <= 16'd3000;
      batt_nominal_r   <= 16'd4100;
      charge_cutoff_r  <= 15'd50;
      supply_low_r     <= 16'd4600;
      supply_min_r     <= 16'd4300;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BATT_ABSENT:    batt_absent_r    <= cfg_wdata;
        REG_BATT_UNDER:     batt_under_r     <= cfg_wdata;
        REG_BATT_OVER:      batt_over_r      <= cfg_wdata;
        REG_BATT_PRECHARGE: batt_precharge_r <= cfg_wdata;
        REG_BATT_NOMINAL:   batt_nominal_r   <= cfg_wdata;
        REG_CHARGE_CUTOFF:  charge_cutoff_r  <= cfg_wdata[14:0];
        REG_SUPPLY_LOW:     supply_low_r     <= cfg_wdata;
        REG_SUPPLY_MIN:     supply_min_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Per-tick decision logic: runs on the transaction held in the input stage
  always_comb begin
    logic [15:0] sup, bat, dwell;
    logic        pending;
    logic [6:0]  hit;
    logic        faulty;
    logic [2:0]  pm;
    logic [1:0]  cm;
    logic [6:0]  fw;
    logic        gain;
    logic        gate;
    logic [1:0]  mode;

    sup     = s1_data_r.supply_mv;
    bat     = s1_data_r.battery_mv;
    dwell   = s1_data_r.dwell_count;
    pending = pulse_pending_r | s1_data_r.five_sec_pulse;
    cm      = charge_mode_r;
    gain    = gain_select_r;
    gate    = 1'b0;
    mode    = DRV_OFF;

    // Fault checks in priority order; first hit wins
    if (!s1_data_r.soft_trip && s1_data_r.hard_trip)           hit = FLT_SHORT;
    else if (batt_absent_r < bat && bat < batt_under_r)         hit = FLT_BATT_UV;
    else if (batt_over_r < bat)                                 hit = FLT_BATT_OV;
    else if (SUPPLY_ABSENT_MV < sup && sup < supply_min_r)      hit = FLT_SUPPLY_UV;
    else if (SUPPLY_MAX_MV < sup)                               hit = FLT_SUPPLY_OV;
    else                                                        hit = '0;
    faulty = |hit;
    fw     = fault_word_r | hit;
    pm     = faulty ? PS_FAULT : power_mode_r;

    case (pm)
      PS_BOOT: begin
        gain = 1'b0;
        if (supply_low_r < sup && batt_under_r < bat)       pm = PS_NORMAL;
        else if (sup < supply_low_r && batt_under_r < bat)  pm = PS_STANDBY;
        else if (supply_low_r < sup && bat < batt_absent_r) pm = PS_EXTERNAL;
        else begin
          pm = PS_FAULT;
          fw = fw | FLT_BAD_POWER;
        end
      end
      PS_STANDBY: begin
        if (supply_low_r < sup) pm = PS_NORMAL;
      end
      PS_EXTERNAL: begin
        if (batt_under_r < bat) pm = PS_NORMAL;
      end
      PS_NORMAL: begin
        if (bat < batt_absent_r) begin
          pm = PS_EXTERNAL;
        end else begin
          case (cm)
            CS_PRE: begin
              if (batt_precharge_r < bat) cm = CS_CHG;
            end
            CS_CHG: begin
              if (pending && (s1_data_r.battery_ma < $signed({1'b0, charge_cutoff_r})))
                cm = CS_DONE;
            end
            CS_DONE: begin
              if (pending && bat < batt_nominal_r) cm = CS_CHG;
            end
            default: begin
              pm = PS_FAULT;
              fw = fw | FLT_BAD_CHARGE;
            end
          endcase
        end
      end
      PS_DISCH: begin
        if (dwell >= DWELL_SLOW) gain = 1'b0;
        if (bat < batt_precharge_r) begin
          pm = PS_STANDBY;
        end else if (pending) begin
          pending = 1'b0;
          pm      = PS_NORMAL;
        end
      end
      PS_FAULT: begin
        if (pending) begin
          pending = 1'b0;
          if (!faulty) pm = PS_BOOT;
        end
      end
      default: begin
        pm = PS_FAULT;
        fw = fw | FLT_BAD_POWER;
      end
    endcase

    // Supply lost while normal: drop to battery and switch to fast gains
    if (pm == PS_NORMAL && sup < supply_low_r) begin
      pm   = PS_DISCH;
      gain = 1'b1;
    end

    if (pm == PS_NORMAL) begin
      if (cm == CS_PRE) begin
        gate = 1'b1;
        mode = DRV_BUCK_QTR;
      end else if (cm == CS_CHG) begin
        gate = 1'b1;
        mode = DRV_BUCK_FULL;
      end else if (cm != CS_DONE) begin
        pm = PS_FAULT;
        fw = fw | FLT_BAD_CHARGE;
      end
    end else if (pm == PS_DISCH) begin
      gate = 1'b1;
      mode = DRV_BOOST;
    end

    power_mode_nxt    = pm;
    charge_mode_nxt   = cm;
    fault_word_nxt    = fw;
    gain_select_nxt   = gain;
    pulse_pending_nxt = pending;

    out_data_nxt.power_state  = pm;
    out_data_nxt.charge_state = cm;
    out_data_nxt.gate_enable  = gate;
    out_data_nxt.drive_mode   = mode;
    out_data_nxt.fast_gains   = gain;
    out_data_nxt.fault_codes  = fw;
  end

  // Control state and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      power_mode_r    <= PS_BOOT;
      charge_mode_r   <= CS_DONE;
      fault_word_r    <= '0;
      gain_select_r   <= 1'b0;
      pulse_pending_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (advance) begin
        out_valid_r     <= 1'b1;
        power_mode_r    <= power_mode_nxt;
        charge_mode_r   <= charge_mode_nxt;
        fault_word_r    <= fault_word_nxt;
        gain_select_r   <= gain_select_nxt;
        pulse_pending_r <= pulse_pending_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold unless loaded
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) s1_data_r  <= in_data;
    if (advance)              out_data_r <= out_data_nxt;
  end

  // Fault word is sticky: bits never clear outside reset
  a_fault_sticky: assert property (@(posedge clk)
    $past(rst_n) |-> ((fault_word_r & $past(fault_word_r)) == $past(fault_word_r)))
    else $error("fault word lost a bit");

  // Gate drive only in normal or discharging, and drive mode tracks the gate
  a_gate_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.gate_enable == (out_data_r.drive_mode != DRV_OFF)) &&
                     (!out_data_r.gate_enable || out_data_r.power_state == PS_NORMAL ||
                      out_data_r.power_state == PS_DISCH)))
    else $error("gate and drive mode inconsistent with power state");

  // No accept while both stages are full and the result is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted with pipeline full");

  // Result register loads only from a valid input stage
  a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(out_valid_r) && out_valid_r && $past(rst_n)) |-> $past(s1_valid_r))
    else $error("result appeared without a transaction");

endmodule
